FILE: hdl/csf_pkg.sv
package csf_pkg;

    // Field widths
    localparam int CmdW     = 2;
    localparam int VerW     = 16;
    localparam int HzW      = 33;
    localparam int StateW   = 3;
    localparam int ErrW     = 4;
    localparam int CountW   = 24;
    localparam int IdW      = 32;
    localparam int CfgIdxW  = 2;

    // Commands
    localparam logic [CmdW-1:0] CMD_POLL      = 2'd0;
    localparam logic [CmdW-1:0] CMD_CONFIGURE = 2'd1;
    localparam logic [CmdW-1:0] CMD_START     = 2'd2;
    localparam logic [CmdW-1:0] CMD_STOP      = 2'd3;

    // Sequencer states
    localparam logic [StateW-1:0] ST_IDLE   = 3'd0;
    localparam logic [StateW-1:0] ST_CONF   = 3'd1;
    localparam logic [StateW-1:0] ST_SETLO  = 3'd2;
    localparam logic [StateW-1:0] ST_WLOCK  = 3'd3;
    localparam logic [StateW-1:0] ST_ARM    = 3'd4;
    localparam logic [StateW-1:0] ST_WFRAME = 3'd5;
    localparam logic [StateW-1:0] ST_ERROR  = 3'd6;

    // Error codes
    localparam logic [ErrW-1:0] E_NONE     = 4'd0;
    localparam logic [ErrW-1:0] E_BADCFG   = 4'd1;
    localparam logic [ErrW-1:0] E_BUSY     = 4'd2;
    localparam logic [ErrW-1:0] E_NOTCFG   = 4'd3;
    localparam logic [ErrW-1:0] E_LOSET    = 4'd4;
    localparam logic [ErrW-1:0] E_LOLOCK   = 4'd5;
    localparam logic [ErrW-1:0] E_DMA      = 4'd6;
    localparam logic [ErrW-1:0] E_FTMO     = 4'd7;
    localparam logic [ErrW-1:0] E_PROC     = 4'd8;
    localparam logic [ErrW-1:0] E_STREAM   = 4'd9;
    localparam logic [ErrW-1:0] E_STOPPED  = 4'd10;
    localparam logic [ErrW-1:0] E_DMARESET = 4'd11;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_TIMEOUT    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_VERSION    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_CENTER_MIN = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_CENTER_MAX = 2'd3;

    // Register reset values
    localparam logic [CountW-1:0] TIMEOUT_RST    = 24'd500000;
    localparam logic [VerW-1:0]   VERSION_RST    = 16'd1;
    localparam logic [HzW-1:0]    CENTER_MIN_RST = 33'd0;
    localparam logic [HzW-1:0]    CENTER_MAX_RST = 33'd8000000000;

    // One input item
    typedef struct packed {
        logic [CmdW-1:0] cmd;
        logic [VerW-1:0] cfg_version;
        logic [HzW-1:0]  cfg_center_hz;
        logic            lo_set_ok;
        logic            lo_locked;
        logic            dma_reset_ok;
        logic            dma_start_ok;
        logic            dma_error;
        logic            frame_ready;
        logic            process_ok;
        logic            stream_ok;
    } item_t;

    // One result item
    typedef struct packed {
        logic              ok;
        logic [StateW-1:0] fsm_state;
        logic              configured;
        logic              active;
        logic [ErrW-1:0]   fault_code;
        logic [IdW-1:0]    trace_id;
        logic [IdW-1:0]    delivered_count;
        logic [IdW-1:0]    dma_errors;
        logic [HzW-1:0]    center_hz;
        logic              frame_delivered;
        logic              status_event;
    } result_t;

endpackage

FILE: hdl/capture_sequencer_fsm.sv
// Capture sequencer: one status item per command or poll item.
// Each item passes through the input register, then the result register, before its result is valid.
// Throughput: one item per cycle while out_ready stays high.
// While a result waits on out_ready the input register holds one more item, then in_ready drops.
// Reset (rst_n low, asynchronous): idle, unconfigured, counters cleared, trace id 1,
// configuration registers at their defaults.
module capture_sequencer_fsm
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [csf_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [csf_pkg::HzW-1:0]        cfg_data,
    // Input item channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [csf_pkg::CmdW-1:0]       cmd,
    input  logic [csf_pkg::VerW-1:0]       cfg_version,
    input  logic [csf_pkg::HzW-1:0]        cfg_center_hz,
    input  logic                           lo_set_ok,
    input  logic                           lo_locked,
    input  logic                           dma_reset_ok,
    input  logic                           dma_start_ok,
    input  logic                           dma_error,
    input  logic                           frame_ready,
    input  logic                           process_ok,
    input  logic                           stream_ok,
    // Result item channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           ok,
    output logic [csf_pkg::StateW-1:0]     fsm_state,
    output logic                           configured,
    output logic                           active,
    output logic [csf_pkg::ErrW-1:0]       fault_code,
    output logic [csf_pkg::IdW-1:0]        trace_id,
    output logic [csf_pkg::IdW-1:0]        delivered_count,
    output logic [csf_pkg::IdW-1:0]        dma_errors,
    output logic [csf_pkg::HzW-1:0]        center_hz,
    output logic                           frame_delivered,
    output logic                           status_event
);

    // Configuration registers
    logic [csf_pkg::CountW-1:0] timeout_loops_reg;
    logic [csf_pkg::VerW-1:0]   expected_version_reg;
    logic [csf_pkg::HzW-1:0]    center_min_reg;
    logic [csf_pkg::HzW-1:0]    center_max_reg;

    // Sequencer state
    logic [csf_pkg::StateW-1:0] fsm_reg, fsm_next;
    logic                       configured_reg, configured_next;
    logic                       stop_pending_reg, stop_pending_next;
    logic [csf_pkg::CountW-1:0] wait_count_reg, wait_count_next;
    logic [csf_pkg::ErrW-1:0]   last_error_reg, last_error_next;
    logic [csf_pkg::IdW-1:0]    next_id_reg, next_id_next;
    logic [csf_pkg::IdW-1:0]    sent_count_reg, sent_count_next;
    logic [csf_pkg::IdW-1:0]    dma_total_reg, dma_total_next;
    logic [csf_pkg::HzW-1:0]    center_reg, center_next;

    // Pipeline registers
    csf_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    csf_pkg::result_t out_item_reg;
    csf_pkg::result_t result_next;
    logic             out_valid_reg;

    logic                       in_accept;
    logic                       advance;
    logic                       is_act;
    logic [csf_pkg::CountW-1:0] wait_inc;
    logic                       expired;
    logic [csf_pkg::ErrW-1:0]   cause;
    logic                       ok_w;
    logic                       event_w;
    logic                       delivered_w;
    logic [csf_pkg::IdW-1:0]    id_inc;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    // Configuration writes; the user must issue them only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_loops_reg    <= csf_pkg::TIMEOUT_RST;
            expected_version_reg <= csf_pkg::VERSION_RST;
            center_min_reg       <= csf_pkg::CENTER_MIN_RST;
            center_max_reg       <= csf_pkg::CENTER_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                csf_pkg::REG_TIMEOUT:    timeout_loops_reg <= cfg_data[csf_pkg::CountW-1:0];
                csf_pkg::REG_VERSION:    expected_version_reg <= cfg_data[csf_pkg::VerW-1:0];
                csf_pkg::REG_CENTER_MIN: center_min_reg <= cfg_data;
                csf_pkg::REG_CENTER_MAX: center_max_reg <= cfg_data;
                default:                 center_max_reg <= center_max_reg;
            endcase
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.cmd           <= cmd;
            in_item_reg.cfg_version   <= cfg_version;
            in_item_reg.cfg_center_hz <= cfg_center_hz;
            in_item_reg.lo_set_ok     <= lo_set_ok;
            in_item_reg.lo_locked     <= lo_locked;
            in_item_reg.dma_reset_ok  <= dma_reset_ok;
            in_item_reg.dma_start_ok  <= dma_start_ok;
            in_item_reg.dma_error     <= dma_error;
            in_item_reg.frame_ready   <= frame_ready;
            in_item_reg.process_ok    <= process_ok;
            in_item_reg.stream_ok     <= stream_ok;
        end
    end

    // Helpers for the active-state check, the wait timeout and the trace id.
    assign is_act   = fsm_reg inside {[csf_pkg::ST_SETLO:csf_pkg::ST_WFRAME]};
    assign wait_inc = wait_count_reg + 1'b1;
    assign expired  = wait_inc >= timeout_loops_reg;
    assign id_inc   = next_id_reg + 1'b1;

    // One step of the sequencer for the item in the input register.
    always_comb
    begin
        fsm_next          = fsm_reg;
        configured_next   = configured_reg;
        stop_pending_next = stop_pending_reg;
        wait_count_next   = wait_count_reg;
        last_error_next   = last_error_reg;
        next_id_next      = next_id_reg;
        sent_count_next   = sent_count_reg;
        dma_total_next    = dma_total_reg;
        center_next       = center_reg;
        cause             = csf_pkg::E_NONE;
        ok_w              = 1'b1;
        event_w           = 1'b0;
        delivered_w       = 1'b0;

        case (in_item_reg.cmd)
            csf_pkg::CMD_CONFIGURE:
            begin
                if ((in_item_reg.cfg_version != expected_version_reg) ||
                    (in_item_reg.cfg_center_hz < center_min_reg) ||
                    (in_item_reg.cfg_center_hz > center_max_reg) || is_act)
                begin
                    last_error_next = csf_pkg::E_BADCFG;
                    ok_w            = 1'b0;
                end
                else
                begin
                    center_next     = in_item_reg.cfg_center_hz;
                    configured_next = 1'b1;
                    last_error_next = csf_pkg::E_NONE;
                    fsm_next        = csf_pkg::ST_CONF;
                end
            end
            csf_pkg::CMD_START:
            begin
                if (is_act)
                begin
                    last_error_next = csf_pkg::E_BUSY;
                    ok_w            = 1'b0;
                end
                else if (!configured_reg)
                begin
                    last_error_next = csf_pkg::E_NOTCFG;
                    ok_w            = 1'b0;
                end
                else
                begin
                    stop_pending_next = 1'b0;
                    wait_count_next   = '0;
                    last_error_next   = csf_pkg::E_NONE;
                    fsm_next          = csf_pkg::ST_SETLO;
                end
            end
            csf_pkg::CMD_STOP:
            begin
                if (is_act)
                begin
                    stop_pending_next = 1'b1;
                end
            end
            default:
            begin
                if (stop_pending_reg)
                begin
                    // A pending stop takes precedence over the sequence step.
                    stop_pending_next = 1'b0;
                    last_error_next   = in_item_reg.dma_reset_ok ? csf_pkg::E_STOPPED
                                                                 : csf_pkg::E_DMARESET;
                    if (!in_item_reg.dma_reset_ok)
                    begin
                        dma_total_next = dma_total_reg + 1'b1;
                    end
                    fsm_next = csf_pkg::ST_IDLE;
                    event_w  = 1'b1;
                    ok_w     = in_item_reg.dma_reset_ok;
                end
                else
                begin
                    case (fsm_reg)
                        csf_pkg::ST_SETLO:
                        begin
                            if (!in_item_reg.lo_set_ok)
                            begin
                                cause = csf_pkg::E_LOSET;
                            end
                            else
                            begin
                                wait_count_next = '0;
                                fsm_next        = csf_pkg::ST_WLOCK;
                            end
                        end
                        csf_pkg::ST_WLOCK:
                        begin
                            if (in_item_reg.lo_locked)
                            begin
                                fsm_next = csf_pkg::ST_ARM;
                            end
                            else
                            begin
                                wait_count_next = wait_inc;
                                if (expired)
                                begin
                                    cause = csf_pkg::E_LOLOCK;
                                end
                            end
                        end
                        csf_pkg::ST_ARM:
                        begin
                            if (!in_item_reg.dma_reset_ok || !in_item_reg.dma_start_ok)
                            begin
                                cause = csf_pkg::E_DMA;
                            end
                            else
                            begin
                                wait_count_next = '0;
                                fsm_next        = csf_pkg::ST_WFRAME;
                            end
                        end
                        csf_pkg::ST_WFRAME:
                        begin
                            if (in_item_reg.dma_error)
                            begin
                                cause = csf_pkg::E_DMA;
                            end
                            else if (in_item_reg.frame_ready)
                            begin
                                if (!in_item_reg.process_ok)
                                begin
                                    cause = csf_pkg::E_PROC;
                                end
                                else if (!in_item_reg.stream_ok)
                                begin
                                    cause = csf_pkg::E_STREAM;
                                end
                                else
                                begin
                                    delivered_w = 1'b1;
                                end
                            end
                            else
                            begin
                                wait_count_next = wait_inc;
                                if (expired)
                                begin
                                    cause = csf_pkg::E_FTMO;
                                end
                            end
                        end
                        default:
                        begin
                            cause = csf_pkg::E_NONE;
                        end
                    endcase

                    // Failure: a failed capture reset overrides the cause.
                    if (cause != csf_pkg::E_NONE)
                    begin
                        last_error_next = in_item_reg.dma_reset_ok ? cause
                                                                   : csf_pkg::E_DMARESET;
                        if ((cause == csf_pkg::E_DMA) || (cause == csf_pkg::E_FTMO) ||
                            !in_item_reg.dma_reset_ok)
                        begin
                            dma_total_next = dma_total_reg + 1'b1;
                        end
                        fsm_next = csf_pkg::ST_ERROR;
                        event_w  = 1'b1;
                        ok_w     = 1'b0;
                    end
                end
            end
        endcase

        // A delivered frame advances the trace id, skipping zero, and rearms.
        if (delivered_w)
        begin
            next_id_next    = (id_inc == '0) ? {{(csf_pkg::IdW-1){1'b0}}, 1'b1} : id_inc;
            sent_count_next = sent_count_reg + 1'b1;
            fsm_next        = csf_pkg::ST_ARM;
        end

        result_next.ok              = ok_w;
        result_next.fsm_state       = fsm_next;
        result_next.configured      = configured_next;
        result_next.active          = fsm_next inside {[csf_pkg::ST_SETLO:csf_pkg::ST_WFRAME]};
        result_next.fault_code      = last_error_next;
        result_next.trace_id        = next_id_reg;
        result_next.delivered_count = sent_count_next;
        result_next.dma_errors      = dma_total_next;
        result_next.center_hz       = center_next;
        result_next.frame_delivered = delivered_w;
        result_next.status_event    = event_w;
    end

    // Control and sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            fsm_reg          <= csf_pkg::ST_IDLE;
            configured_reg   <= 1'b0;
            stop_pending_reg <= 1'b0;
            wait_count_reg   <= '0;
            last_error_reg   <= csf_pkg::E_NONE;
            next_id_reg      <= {{(csf_pkg::IdW-1){1'b0}}, 1'b1};
            sent_count_reg   <= '0;
            dma_total_reg    <= '0;
            center_reg       <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                fsm_reg          <= fsm_next;
                configured_reg   <= configured_next;
                stop_pending_reg <= stop_pending_next;
                wait_count_reg   <= wait_count_next;
                last_error_reg   <= last_error_next;
                next_id_reg      <= next_id_next;
                sent_count_reg   <= sent_count_next;
                dma_total_reg    <= dma_total_next;
                center_reg       <= center_next;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = out_item_reg.ok;
    assign fsm_state       = out_item_reg.fsm_state;
    assign configured      = out_item_reg.configured;
    assign active          = out_item_reg.active;
    assign fault_code      = out_item_reg.fault_code;
    assign trace_id        = out_item_reg.trace_id;
    assign delivered_count = out_item_reg.delivered_count;
    assign dma_errors      = out_item_reg.dma_errors;
    assign center_hz       = out_item_reg.center_hz;
    assign frame_delivered = out_item_reg.frame_delivered;
    assign status_event    = out_item_reg.status_event;

endmodule

FILE: hdl/csf_checker.sv
module csf_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       ok,
    input logic [csf_pkg::StateW-1:0] fsm_state,
    input logic                       active,
    input logic [csf_pkg::IdW-1:0]    trace_id,
    input logic                       frame_delivered,
    input logic                       status_event
);

    // The active flag agrees with the reported state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active == ((fsm_state >= csf_pkg::ST_SETLO) &&
                                  (fsm_state <= csf_pkg::ST_WFRAME))))
        else $error("active flag disagrees with state");

    // The trace id never reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (trace_id != '0))
        else $error("trace id is zero");

    // A delivered frame rearms the capture and is a clean success.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_delivered) |->
            (ok && !status_event && (fsm_state == csf_pkg::ST_ARM)))
        else $error("delivery with wrong status");

    // A status event in the error state is always reported as a failure.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (fsm_state == csf_pkg::ST_ERROR) && status_event) |-> !ok)
        else $error("error event reported as success");

    // A stalled result item stays valid and keeps its trace id.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(trace_id)))
        else $error("stalled result item changed");

endmodule

bind capture_sequencer_fsm csf_checker u_csf_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .ok              (ok),
    .fsm_state       (fsm_state),
    .active          (active),
    .trace_id        (trace_id),
    .frame_delivered (frame_delivered),
    .status_event    (status_event)
);
